// ===== design/coulomb_matrix_element_unit_assert.svh =====
// Assertion macros for the Coulomb matrix element unit.
// Included by the RTL files that carry concurrent assertions; needs no package.
`ifndef COULOMB_MATRIX_ELEMENT_UNIT_ASSERT_SVH
`define COULOMB_MATRIX_ELEMENT_UNIT_ASSERT_SVH

// A property checked at every clock edge outside of reset.
`define CMEU_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must be followed by a property in the next cycle.
`define CMEU_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== design/cmeu_pkg.sv =====
// Package of the Coulomb matrix element unit: field widths, codes and defaults.
// Used by the reciprocal pipeline and the top level; depends on nothing.
package cmeu_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int COORD_BITS_DEF  = 5;

   localparam int IDX_BITS      = 8;
   localparam int IN_COORD_BITS = 5;
   localparam int SCALE_W       = 24;
   localparam int VALUE_W       = 25;
   localparam int REQ_TDATA_W   = 56;
   localparam int RSP_TDATA_W   = 32;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Reciprocal floor(2^FRAC_BITS / d), computed four quotient bits per stage.
   localparam int FRAC_BITS    = 16;
   localparam int RECIP_Q_BITS = FRAC_BITS + 1;
   localparam int RECIP_BPS    = 4;
   localparam int RECIP_STAGES = (RECIP_Q_BITS + RECIP_BPS - 1) / RECIP_BPS;

   typedef struct packed {
      logic conserved;
      logic dir_en;
      logic exc_en;
   } cmeu_side_type;

endpackage

// ===== design/cmeu_recip.sv =====
// Pipelined restoring divider that forms floor(2^FRAC_BITS / den).
// Uses cmeu_pkg for the quotient width and the number of bits per stage.
module cmeu_recip
   import cmeu_pkg::*;
#(
   parameter int D_W = 2 * COORD_BITS_DEF + 2
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [D_W-1:0]          den,
   output logic [RECIP_Q_BITS-1:0] quot
);

   localparam int RW = D_W + 1;

   logic [RW-1:0]           rem_ff  [RECIP_STAGES-1];
   logic [D_W-1:0]          den_ff  [RECIP_STAGES-1];
   logic [RECIP_Q_BITS-1:0] quot_ff [RECIP_STAGES];

   for (genvar s = 0; s < RECIP_STAGES; s++) begin : g_stage
      logic [RW-1:0]           rem_prev;
      logic [RW-1:0]           rem_in;
      logic [RECIP_Q_BITS-1:0] quot_prev;
      logic [RECIP_Q_BITS-1:0] quot_in;
      logic [D_W-1:0]          den_prev;

      if (s == 0) begin : g_head
         assign rem_prev  = '0;
         assign quot_prev = '0;
         assign den_prev  = den;
      end else begin : g_body
         assign rem_prev  = rem_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign den_prev  = den_ff[s-1];
      end

      always_comb begin
         rem_in  = rem_prev;
         quot_in = quot_prev;
         for (int t = 0; t < RECIP_BPS; t++) begin
            if (s * RECIP_BPS + t < RECIP_Q_BITS) begin
               // The dividend is a single one in its top bit.
               rem_in = {rem_in[RW-2:0], (s * RECIP_BPS + t == 0)};
               if (rem_in >= {1'b0, den_prev}) begin
                  rem_in  = rem_in - {1'b0, den_prev};
                  quot_in = {quot_in[RECIP_Q_BITS-2:0], 1'b1};
               end else begin
                  quot_in = {quot_in[RECIP_Q_BITS-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            quot_ff[s] <= quot_in;
         end
      end

      if (s < RECIP_STAGES - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_prev;
            end
         end
      end
   end

   assign quot = quot_ff[RECIP_STAGES-1];

endmodule

// ===== design/coulomb_matrix_element_unit.sv =====
// Top level of the Coulomb matrix element unit: state table, pipeline and output skid.
// Depends on cmeu_pkg, cmeu_recip and coulomb_matrix_element_unit_assert.svh.
//
//   Channel | Direction | Moves
//   req_*   | in        | load item (tuser 0) or query item (tuser 1)
//   rsp_*   | out       | one matrix element item per query item
//   csr_*   | in        | coupling scale write, always ready
//
// One item is accepted per cycle while the skid register is empty.
// A query result passes the table read, distance, divider stage and product registers on
// to the output register; the reciprocal dividers resolve four quotient bits per stage.
// Reset clears the valid bits and presets the scale; the state table is not cleared.
// A stalled output parks one result in the skid register and then holds the input.
`include "coulomb_matrix_element_unit_assert.svh"

module coulomb_matrix_element_unit
   import cmeu_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // load_index, load_nx, load_ny, load_nz, load_spin, index_first, index_second,
   // index_third, index_fourth
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // func
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // element_value, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // momentum_conserved
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SCALE_W-1:0]     csr_data
);

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int EXT_W   = (ADDR_W > IDX_BITS ? ADDR_W : IDX_BITS) + 1;
   localparam int C       = COORD_BITS;
   localparam int ENTRY_W = 3 * C + 1;
   localparam int D_W     = 2 * C + 2;
   localparam int PROD_W  = SCALE_W + RECIP_Q_BITS + 2;

   logic [SCALE_W-1:0] scale_ff;

   logic [ENTRY_W-1:0] mem_a [TABLE_DEPTH];
   logic [ENTRY_W-1:0] mem_b [TABLE_DEPTH];

   logic adv;
   logic in_acc;
   logic load_acc;
   logic query_acc;

   logic signed [IN_COORD_BITS-1:0] ld_nx;
   logic signed [IN_COORD_BITS-1:0] ld_ny;
   logic signed [IN_COORD_BITS-1:0] ld_nz;
   logic [ENTRY_W-1:0]              wr_entry;
   logic [EXT_W-1:0]                idx_ext [5];
   logic [ADDR_W-1:0]               addr    [5];
   logic [4:0]                      in_range;

   logic [ENTRY_W-1:0] rd_ff [4];
   logic [3:0]         s0_inr_ff;
   logic               s0_valid_ff;

   logic [ENTRY_W-1:0]   ent   [4];
   logic signed [C-1:0]  kc    [4][3];
   logic signed [C:0]    dr    [3];
   logic signed [C:0]    de    [3];
   logic [C-1:0]         mr    [3];
   logic [C-1:0]         me    [3];
   logic [2:0]           comp_eq;
   logic [D_W-1:0]       d_dir_c;
   logic [D_W-1:0]       d_exc_c;
   cmeu_side_type        side_c;

   logic                 s1_valid_ff;
   cmeu_side_type        s1_side_ff;
   logic [D_W-1:0]       s1_d_dir_ff;
   logic [D_W-1:0]       s1_d_exc_ff;

   logic                 side_valid_ff [RECIP_STAGES];
   cmeu_side_type        side_ff       [RECIP_STAGES];

   logic [RECIP_Q_BITS-1:0]   q_dir;
   logic [RECIP_Q_BITS-1:0]   q_exc;
   logic [RECIP_Q_BITS-1:0]   qd_m;
   logic [RECIP_Q_BITS-1:0]   qe_m;
   logic signed [RECIP_Q_BITS:0] diff_c;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      m_valid_ff;
   logic                      m_cons_ff;
   logic [VALUE_W-1:0]        res_value;

   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_cons_ff;
   logic               skid_valid_ff;
   logic [VALUE_W-1:0] skid_value_ff;
   logic               skid_cons_ff;
   logic               take;

   // Configuration.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_data;
      end
   end

   // Input decode and table access.
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign in_acc     = req_tvalid && req_tready;
   assign load_acc   = in_acc && (req_tuser == FUNC_LOAD);
   assign query_acc  = in_acc && (req_tuser == FUNC_QUERY);

   assign ld_nx    = req_tdata[12:8];
   assign ld_ny    = req_tdata[17:13];
   assign ld_nz    = req_tdata[22:18];
   assign wr_entry = {req_tdata[23], C'(ld_nz), C'(ld_ny), C'(ld_nx)};

   assign idx_ext[0] = EXT_W'(req_tdata[7:0]);
   assign idx_ext[1] = EXT_W'(req_tdata[31:24]);
   assign idx_ext[2] = EXT_W'(req_tdata[39:32]);
   assign idx_ext[3] = EXT_W'(req_tdata[47:40]);
   assign idx_ext[4] = EXT_W'(req_tdata[55:48]);

   always_comb begin
      for (int n = 0; n < 5; n++) begin
         in_range[n] = idx_ext[n] < EXT_W'(TABLE_DEPTH);
         addr[n]     = idx_ext[n][ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && in_range[0]) begin
         mem_a[addr[0]] <= wr_entry;
         mem_b[addr[0]] <= wr_entry;
      end
      if (adv) begin
         rd_ff[0]  <= mem_a[addr[1]];
         rd_ff[1]  <= mem_a[addr[2]];
         rd_ff[2]  <= mem_b[addr[3]];
         rd_ff[3]  <= mem_b[addr[4]];
         s0_inr_ff <= in_range[4:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= query_acc;
      end
   end

   // Momentum check and squared distances.
   always_comb begin
      for (int n = 0; n < 4; n++) begin
         ent[n] = s0_inr_ff[n] ? rd_ff[n] : '0;
         for (int c = 0; c < 3; c++) begin
            kc[n][c] = ent[n][c*C +: C];
         end
      end
      d_dir_c = '0;
      d_exc_c = '0;
      for (int c = 0; c < 3; c++) begin
         comp_eq[c] = ((C+1)'(kc[0][c]) + (C+1)'(kc[1][c])) ==
                      ((C+1)'(kc[2][c]) + (C+1)'(kc[3][c]));
         dr[c] = (C+1)'(kc[2][c]) - (C+1)'(kc[0][c]);
         de[c] = (C+1)'(kc[3][c]) - (C+1)'(kc[0][c]);
         mr[c] = dr[c][C] ? C'(-dr[c]) : C'(dr[c]);
         me[c] = de[c][C] ? C'(-de[c]) : C'(de[c]);
         d_dir_c = d_dir_c + D_W'(mr[c]) * D_W'(mr[c]);
         d_exc_c = d_exc_c + D_W'(me[c]) * D_W'(me[c]);
      end
      side_c.conserved = &comp_eq;
      side_c.dir_en = (ent[0][3*C] == ent[2][3*C]) && (ent[1][3*C] == ent[3][3*C]) &&
                      (d_dir_c != '0);
      side_c.exc_en = (ent[0][3*C] == ent[3][3*C]) && (ent[1][3*C] == ent[2][3*C]) &&
                      (d_exc_c != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_side_ff  <= side_c;
         s1_d_dir_ff <= d_dir_c;
         s1_d_exc_ff <= d_exc_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   // Reciprocals of both distances, with the flags riding alongside.
   cmeu_recip #(.D_W(D_W)) u_recip_dir (
      .clock  (clock),
      .enable (adv),
      .den    (s1_d_dir_ff),
      .quot   (q_dir)
   );

   cmeu_recip #(.D_W(D_W)) u_recip_exc (
      .clock  (clock),
      .enable (adv),
      .den    (s1_d_exc_ff),
      .quot   (q_exc)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= s1_side_ff;
         for (int i = 1; i < RECIP_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RECIP_STAGES; i++) begin
            side_valid_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         side_valid_ff[0] <= s1_valid_ff;
         for (int i = 1; i < RECIP_STAGES; i++) begin
            side_valid_ff[i] <= side_valid_ff[i-1];
         end
      end
   end

   // Scaling.
   assign qd_m    = side_ff[RECIP_STAGES-1].dir_en ? q_dir : '0;
   assign qe_m    = side_ff[RECIP_STAGES-1].exc_en ? q_exc : '0;
   assign diff_c  = (RECIP_Q_BITS+1)'(qd_m) - (RECIP_Q_BITS+1)'(qe_m);
   assign prod_in = $signed({1'b0, scale_ff}) * diff_c;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= prod_in;
         m_cons_ff <= side_ff[RECIP_STAGES-1].conserved;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= side_valid_ff[RECIP_STAGES-1];
      end
   end

   // The arithmetic shift floors toward minus infinity.
   assign res_value = m_cons_ff ? prod_ff[FRAC_BITS +: VALUE_W] : '0;

   // Output register with one skid entry.
   assign take = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (m_valid_ff) begin
         if (take || !out_valid_ff) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_value_ff <= skid_value_ff;
            out_cons_ff  <= skid_cons_ff;
         end
      end else if (m_valid_ff) begin
         if (take || !out_valid_ff) begin
            out_value_ff <= res_value;
            out_cons_ff  <= m_cons_ff;
         end else begin
            skid_value_ff <= res_value;
            skid_cons_ff  <= m_cons_ff;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-VALUE_W){1'b0}}, out_value_ff};
   assign rsp_tuser  = out_cons_ff;

   `CMEU_ASSERT_ALWAYS(a_skid_needs_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid entry held while output register is empty")
   `CMEU_ASSERT_ALWAYS(a_skid_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready), "skid entry filled without an output stall")
   `CMEU_ASSERT_ALWAYS(a_zero_when_broken, clock, reset, (out_valid_ff && !out_cons_ff) |-> (out_value_ff == '0), "nonzero element without momentum conservation")
   `CMEU_ASSERT_NEXT(a_query_enters, clock, reset, query_acc, s0_valid_ff, "accepted query item did not enter the pipeline")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for coulomb_matrix_element_unit: directed and random load and query
// items on the request stream, results checked in order against a behavioral predictor.
// Depends on cmeu_pkg and the unit's RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cmeu_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_REPORTS  = 40;
   localparam int NUM_ENTRIES  = 256;

   typedef enum int {RX_STEADY, RX_SHORT, RX_PERIODIC, RX_LONG} rx_mode_t;

   typedef struct {
      int   kx;
      int   ky;
      int   kz;
      logic spin;
   } plane_wave_t;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               conserved;
   } element_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [SCALE_W-1:0]     csr_data;

   plane_wave_t        wave_table [NUM_ENTRIES];
   logic [SCALE_W-1:0] scale_model;
   element_t           pending_elements [$];

   int       mismatch_count = 0;
   int       cycle_count    = 0;
   int       items_sent     = 0;
   int       tx_gap_max     = 0;
   int       tx_burst_max   = 1;
   int       burst_left     = 0;
   int       rx_stall_left  = 0;
   rx_mode_t rx_mode        = RX_STEADY;

   coulomb_matrix_element_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("coulomb_matrix_element_unit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rx_stall_left > 0) begin
         rx_stall_left <= rx_stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_STEADY: begin
               rsp_tready <= 1'b1;
            end
            RX_PERIODIC: begin
               rsp_tready <= ((cycle_count % 13) < 8);
            end
            RX_SHORT: begin
               if ($urandom_range(0, 3) == 0) begin
                  rsp_tready <= 1'b0;
                  rx_stall_left <= $urandom_range(0, 2);
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  rsp_tready <= 1'b0;
                  rx_stall_left <= $urandom_range(4, 30);
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_elements
      element_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_elements.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, tdata %h", rsp_tdata));
         end else begin
            want = pending_elements.pop_front();
            if (rsp_tdata[VALUE_W-1:0] !== want.value) begin
               report_mismatch($sformatf("element_value %h, expected %h",
                                         rsp_tdata[VALUE_W-1:0], want.value));
            end
            if (rsp_tdata[RSP_TDATA_W-1:VALUE_W] !== '0) begin
               report_mismatch($sformatf("fill bits of tdata not zero: %h", rsp_tdata));
            end
            if (rsp_tuser !== want.conserved) begin
               report_mismatch($sformatf("momentum_conserved %b, expected %b",
                                         rsp_tuser, want.conserved));
            end
         end
      end
   end

   function automatic int recip_sq_dist(input plane_wave_t a, input plane_wave_t b);
      int d;
      d = (a.kx - b.kx) * (a.kx - b.kx) + (a.ky - b.ky) * (a.ky - b.ky)
        + (a.kz - b.kz) * (a.kz - b.kz);
      return (d == 0) ? 0 : 65536 / d;
   endfunction

   function automatic element_t predict_element(input logic [7:0] p, input logic [7:0] q,
                                                input logic [7:0] r, input logic [7:0] s);
      element_t    e;
      plane_wave_t wp, wq, wr, ws;
      int          direct = 0;
      int          exchange = 0;
      longint      product;
      wp = wave_table[p];
      wq = wave_table[q];
      wr = wave_table[r];
      ws = wave_table[s];
      if (wp.kx + wq.kx != wr.kx + ws.kx || wp.ky + wq.ky != wr.ky + ws.ky ||
          wp.kz + wq.kz != wr.kz + ws.kz) begin
         e.value = '0;
         e.conserved = 1'b0;
         return e;
      end
      if (wp.spin == wr.spin && wq.spin == ws.spin) direct = recip_sq_dist(wr, wp);
      if (wp.spin == ws.spin && wq.spin == wr.spin) exchange = recip_sq_dist(ws, wp);
      product = longint'(scale_model) * longint'(direct - exchange);
      product = product >>> 16;
      e.value = product[VALUE_W-1:0];
      e.conserved = 1'b1;
      return e;
   endfunction

   function automatic void apply_item(input logic func, input logic [REQ_TDATA_W-1:0] data);
      logic [7:0] idx;
      if (func == FUNC_LOAD) begin
         idx = data[7:0];
         wave_table[idx].kx = $signed(data[12:8]);
         wave_table[idx].ky = $signed(data[17:13]);
         wave_table[idx].kz = $signed(data[22:18]);
         wave_table[idx].spin = data[23];
      end else begin
         pending_elements.push_back(predict_element(data[31:24], data[39:32],
                                                    data[47:40], data[55:48]));
      end
   endfunction

   task automatic send_item(input logic func, input logic [REQ_TDATA_W-1:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, tx_gap_max);
         burst_left = $urandom_range(1, tx_burst_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= data;
      do @(posedge clock); while (req_tready !== 1'b1);
      apply_item(func, data);
      items_sent++;
   endtask

   task automatic send_load(input int idx, input int nx, input int ny, input int nz,
                            input logic spin);
      logic [REQ_TDATA_W-1:0] w;
      w = REQ_TDATA_W'({$urandom, $urandom});
      w[7:0] = 8'(idx);
      w[12:8] = 5'(nx);
      w[17:13] = 5'(ny);
      w[22:18] = 5'(nz);
      w[23] = spin;
      send_item(FUNC_LOAD, w);
   endtask

   task automatic send_query(input int p, input int q, input int r, input int s);
      logic [REQ_TDATA_W-1:0] w;
      w = REQ_TDATA_W'({$urandom, $urandom});
      w[31:24] = 8'(p);
      w[39:32] = 8'(q);
      w[47:40] = 8'(r);
      w[55:48] = 8'(s);
      send_item(FUNC_QUERY, w);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(input logic [SCALE_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      scale_model = value;
   endtask

   function automatic int rand_coord();
      if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 31)) - 16;
      return int'($urandom_range(0, 6)) - 3;
   endfunction

   task automatic send_conserving_query();
      int p, q, r, s, sx, sy, sz;
      logic spin;
      p = $urandom_range(0, NUM_ENTRIES - 1);
      q = $urandom_range(0, NUM_ENTRIES - 1);
      case ($urandom_range(0, 7))
         0: r = p;
         1: r = q;
         default: r = $urandom_range(0, NUM_ENTRIES - 1);
      endcase
      sx = wave_table[p].kx + wave_table[q].kx - wave_table[r].kx;
      sy = wave_table[p].ky + wave_table[q].ky - wave_table[r].ky;
      sz = wave_table[p].kz + wave_table[q].kz - wave_table[r].kz;
      if (sx >= -16 && sx <= 15 && sy >= -16 && sy <= 15 && sz >= -16 && sz <= 15) begin
         s = $urandom_range(0, NUM_ENTRIES - 1);
         spin = ($urandom_range(0, 1) == 0) ? wave_table[q].spin : 1'($urandom_range(0, 1));
         send_load(s, sx, sy, sz, spin);
         send_query(p, q, r, s);
      end else begin
         send_query(p, q, r, $urandom_range(0, NUM_ENTRIES - 1));
      end
   endtask

   task automatic test_directed_cases();
      tx_gap_max = 2;
      tx_burst_max = 4;
      rx_mode = RX_SHORT;
      send_load(0, 0, 0, 0, 1'b0);
      send_load(1, 1, 0, 0, 1'b0);
      send_load(2, -1, 0, 0, 1'b0);
      send_load(4, -1, 0, 0, 1'b1);
      send_load(7, 0, 0, 0, 1'b1);
      send_load(255, 15, 15, 15, 1'b1);
      send_load(5, -16, -16, -16, 1'b1);
      send_load(6, -1, -1, -1, 1'b1);
      send_query(1, 1, 1, 1);
      send_query(1, 2, 0, 0);
      send_query(1, 2, 2, 1);
      send_query(1, 4, 0, 7);
      send_query(1, 4, 7, 0);
      send_query(255, 5, 6, 7);
      send_query(5, 255, 255, 5);
      send_query(1, 1, 0, 0);
   endtask

   task automatic test_scale_extremes();
      write_scale({SCALE_W{1'b1}});
      send_query(1, 4, 0, 7);
      send_query(1, 4, 7, 0);
      send_query(5, 255, 255, 5);
      write_scale('0);
      send_query(1, 4, 0, 7);
      send_query(255, 5, 6, 7);
   endtask

   task automatic test_table_fill();
      write_scale(SCALE_RESET);
      tx_gap_max = 3;
      tx_burst_max = 10;
      rx_mode = RX_PERIODIC;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         send_load(i, rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_traffic_phase(input logic [SCALE_W-1:0] scale, input int gap_max,
                                    input int burst_max, input rx_mode_t mode,
                                    input int count);
      int stop_at;
      int pick;
      write_scale(scale);
      tx_gap_max = gap_max;
      tx_burst_max = burst_max;
      rx_mode = mode;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            send_load($urandom_range(0, NUM_ENTRIES - 1), rand_coord(), rand_coord(),
                      rand_coord(), 1'($urandom_range(0, 1)));
         end else if (pick < 8) begin
            send_conserving_query();
         end else begin
            send_query($urandom_range(0, NUM_ENTRIES - 1), $urandom_range(0, NUM_ENTRIES - 1),
                       $urandom_range(0, NUM_ENTRIES - 1), $urandom_range(0, NUM_ENTRIES - 1));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(SCALE_W'($urandom), 0, 1, RX_STEADY, 260);
      run_traffic_phase({SCALE_W{1'b1}}, 3, 8, RX_SHORT, 260);
      run_traffic_phase(SCALE_W'($urandom_range(1, 255)), 6, 4, RX_PERIODIC, 260);
      run_traffic_phase(SCALE_W'($urandom), 12, 16, RX_LONG, 260);
      run_traffic_phase('0, 2, 12, RX_SHORT, 130);
      run_traffic_phase(SCALE_W'($urandom), 4, 6, RX_PERIODIC, 130);
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      scale_model = SCALE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_scale_extremes();
      test_table_fill();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("coulomb_matrix_element_unit regression: pass");
      end else begin
         $display("coulomb_matrix_element_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== coulomb_matrix_element_unit.f =====
+incdir+design
design/cmeu_pkg.sv
design/cmeu_recip.sv
design/coulomb_matrix_element_unit.sv
verif/tb_top.sv
